// ----- src/etcp_pkg.sv -----
// ----------------------------------------------------------------------------
// etcp_pkg
// Shared types and constants for the EEPROM transfer chunk planner.
// ----------------------------------------------------------------------------
package etcp_pkg;

    // Request kinds
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_OPEN  = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;
    localparam logic [1:0] ST_NO_DEVICE = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 21;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_ADDR  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WA_BYTES   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BANK_BITS  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAGE_LOG2  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY   = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_BASE_ADDR = 8'd160;
    localparam logic [1:0]  RST_WA_BYTES  = 2'd2;
    localparam logic [1:0]  RST_BANK_BITS = 2'd0;
    localparam logic [3:0]  RST_PAGE_LOG2 = 4'd6;
    localparam logic [20:0] RST_CAPACITY  = 21'd65536;

    typedef struct packed {
        logic [7:0]  base_addr;
        logic [1:0]  wa_bytes;
        logic [1:0]  bank_bits;
        logic [3:0]  page_log2;
        logic [20:0] capacity;
    } t_cfg;

    // One chunk as worked out by the chunk unit
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] word_address;
        logic [7:0]  length;
        logic        last;
    } t_chunk;

    // One result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slave_address;
        logic [15:0] word_address;
        logic [7:0]  chunk_length;
        logic        is_write;
        logic        last;
    } t_result;

endpackage

// ----- src/etcp_req_if.sv -----
// ----------------------------------------------------------------------------
// etcp_req_if
// Request channel: valid/ready handshake with op, length and probe ack.
// ----------------------------------------------------------------------------
interface etcp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] length;
    logic       device_ack;

    modport source (output valid, output op, output length, output device_ack,
                    input ready);
    modport sink   (input valid, input op, input length, input device_ack,
                    output ready);
endinterface

// ----- src/etcp_res_if.sv -----
// ----------------------------------------------------------------------------
// etcp_res_if
// Result channel: valid/ready handshake with one planned chunk or status.
// ----------------------------------------------------------------------------
interface etcp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slave_address;
    logic [15:0] word_address;
    logic [7:0]  chunk_length;
    logic        is_write;
    logic        last;

    modport source (output valid, output status, output slave_address,
                    output word_address, output chunk_length, output is_write,
                    output last, input ready);
    modport sink   (input valid, input status, input slave_address,
                    input word_address, input chunk_length, input is_write,
                    input last, output ready);
endinterface

// ----- src/eeprom_transfer_chunk_planner.sv -----
// ----------------------------------------------------------------------------
// eeprom_transfer_chunk_planner
// Splits EEPROM read/write requests into bank- and page-bounded bus chunks.
// ----------------------------------------------------------------------------
// Flow: a request is accepted in IDLE; a status result (open, close,
//   refusal, empty transfer) is loaded into the output register from
//   S_CHECK, and the chunks of a transfer from S_CHUNK, which follows S_CHECK,
//   one chunk per cycle while the output register is free. A transfer has at
//   most 33 chunks (N <= 33), all worked out by the single chunk unit.
// Reset: synchronous, active low; closes the device, clears the cursor and
//   output valid, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module eeprom_transfer_chunk_planner #(
    parameter int MAX_REQUEST_BYTES = 255,
    parameter int CURSOR_BITS       = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    etcp_req_if.sink                           i_req,
    etcp_res_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [etcp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [etcp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import etcp_pkg::*;

    // wide enough for cursor + length and for the 21-bit capacity
    localparam int AW = (CURSOR_BITS + 2 > 22) ? CURSOR_BITS + 2 : 22;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CHUNK
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_op, n_op;
    logic [7:0]           r_len, n_len;
    logic                 r_ack, n_ack;
    logic [CURSOR_BITS:0] r_cursor, n_cursor;
    logic                 r_open, n_open;
    logic [CURSOR_BITS:0] r_addr, n_addr;
    logic [7:0]           r_left, n_left;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;
    t_cfg                 r_cfg, n_cfg;

    t_chunk               chunk;
    logic                 slot_free;
    logic                 req_accept;
    logic [AW-1:0]        sum;
    logic [AW-1:0]        cap;
    logic [AW-1:0]        lim;
    logic                 too_long;

    // shared chunk arithmetic, reused once per emitted chunk
    etcp_chunk_unit #(
        .CURSOR_BITS (CURSOR_BITS)
    ) u_chunk (
        .i_cfg      (r_cfg),
        .i_addr     (r_addr),
        .i_left     (r_left),
        .i_is_write (r_op == OP_WRITE),
        .o_chunk    (chunk)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && (r_state == S_IDLE);
    // output register is free when empty or being drained this cycle
    assign slot_free   = !r_out_valid || o_res.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.slave_address = r_out.slave_address;
    assign o_res.word_address  = r_out.word_address;
    assign o_res.chunk_length  = r_out.chunk_length;
    assign o_res.is_write      = r_out.is_write;
    assign o_res.last          = r_out.last;

    // capacity check: cursor + length against min(capacity, 2^CURSOR_BITS)
    always_comb begin
        sum = AW'(r_cursor) + AW'(r_len);
        lim = AW'(1) << CURSOR_BITS;
        cap = (AW'(r_cfg.capacity) < lim) ? AW'(r_cfg.capacity) : lim;
        too_long = (r_len > 8'(MAX_REQUEST_BYTES));
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_len       = r_len;
        n_ack       = r_ack;
        n_cursor    = r_cursor;
        n_open      = r_open;
        n_addr      = r_addr;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cfg       = r_cfg;

        // apply a configuration write in any state
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE_ADDR: n_cfg.base_addr = i_cfg_data[7:0];
                REG_WA_BYTES:  n_cfg.wa_bytes  = i_cfg_data[1:0];
                REG_BANK_BITS: n_cfg.bank_bits = i_cfg_data[1:0];
                REG_PAGE_LOG2: n_cfg.page_log2 = i_cfg_data[3:0];
                REG_CAPACITY:  n_cfg.capacity  = i_cfg_data[20:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                // latch the request transaction
                if (req_accept) begin
                    n_op    = i_req.op;
                    n_len   = i_req.length;
                    n_ack   = i_req.device_ack;
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                if (slot_free) begin
                    // non-transfer result template
                    n_out.status        = ST_OK;
                    n_out.slave_address = 8'd0;
                    n_out.word_address  = 16'd0;
                    n_out.chunk_length  = 8'd0;
                    n_out.is_write      = 1'b0;
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                    case (r_op)
                        OP_OPEN: begin
                            if (r_ack) begin
                                n_cursor = '0;
                                n_open   = 1'b1;
                            end else begin
                                n_out.status = ST_NO_DEVICE;
                            end
                        end
                        OP_CLOSE: begin
                            n_open = 1'b0;
                        end
                        default: begin
                            if (!r_open) begin
                                n_out.status = ST_NOT_OPEN;
                            end else if (too_long || (sum > cap)) begin
                                n_out.status = ST_CAPACITY;
                            end else if (r_len != 8'd0) begin
                                // start chunking; nothing emitted this cycle
                                n_out_valid = r_out_valid && !o_res.ready;
                                n_out       = r_out;
                                n_addr      = r_cursor;
                                n_left      = r_len;
                                n_state     = S_CHUNK;
                            end
                        end
                    endcase
                end
            end

            S_CHUNK: begin
                // emit one chunk per free output slot, advance address
                if (slot_free) begin
                    n_out.status        = ST_OK;
                    n_out.slave_address = chunk.slave_address;
                    n_out.word_address  = chunk.word_address;
                    n_out.chunk_length  = chunk.length;
                    n_out.is_write      = (r_op == OP_WRITE);
                    n_out.last          = chunk.last;
                    n_out_valid         = 1'b1;
                    n_addr = r_addr + (CURSOR_BITS + 1)'(chunk.length);
                    n_left = r_left - chunk.length;
                    if (chunk.last) begin
                        n_cursor = r_addr + (CURSOR_BITS + 1)'(chunk.length);
                        n_state  = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cursor        <= '0;
            r_open          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_cfg.base_addr <= RST_BASE_ADDR;
            r_cfg.wa_bytes  <= RST_WA_BYTES;
            r_cfg.bank_bits <= RST_BANK_BITS;
            r_cfg.page_log2 <= RST_PAGE_LOG2;
            r_cfg.capacity  <= RST_CAPACITY;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
        // payload holds no reset
        r_op   <= n_op;
        r_len  <= n_len;
        r_ack  <= n_ack;
        r_addr <= n_addr;
        r_left <= n_left;
        r_out  <= n_out;
    end

endmodule

// ----- src/etcp_chunk_unit.sv -----
// ----------------------------------------------------------------------------
// etcp_chunk_unit
// Shared chunk arithmetic: bank/page room, chunk length, addresses.
// ----------------------------------------------------------------------------
module etcp_chunk_unit #(
    parameter int CURSOR_BITS = 20
) (
    input  etcp_pkg::t_cfg       i_cfg,
    input  logic [CURSOR_BITS:0] i_addr,
    input  logic [7:0]           i_left,
    input  logic                 i_is_write,
    output etcp_pkg::t_chunk     o_chunk
);
    import etcp_pkg::*;

    logic [31:0] addr_ext;
    logic        two_byte;
    logic [3:0]  pl;
    logic [8:0]  page;
    logic [7:0]  page_mask;
    logic [8:0]  page_room;
    logic [16:0] room;
    logic [2:0]  bank_mask;
    logic [2:0]  bank;
    logic [7:0]  n;

    always_comb begin
        addr_ext = 32'(i_addr);
        two_byte = i_cfg.wa_bytes[1];

        // clamp page size to 8..256 bytes
        if (i_cfg.page_log2 < 4'd3) begin
            pl = 4'd3;
        end else if (i_cfg.page_log2 > 4'd8) begin
            pl = 4'd8;
        end else begin
            pl = i_cfg.page_log2;
        end
        page      = 9'd1 << pl;
        page_mask = 8'(page - 9'd1);
        page_room = page - {1'b0, addr_ext[7:0] & page_mask};

        if (two_byte) begin
            room = 17'h10000 - {1'b0, addr_ext[15:0]};
            o_chunk.word_address = addr_ext[15:0];
            bank = addr_ext[18:16];
        end else begin
            room = 17'd256 - {9'd0, addr_ext[7:0]};
            o_chunk.word_address = {8'd0, addr_ext[7:0]};
            bank = addr_ext[10:8];
        end

        if (i_is_write && ({8'd0, page_room} < room)) begin
            room = {8'd0, page_room};
        end

        if ({9'd0, i_left} < room) begin
            n = i_left;
        end else begin
            n = room[7:0];
        end

        bank_mask = 3'((4'd1 << i_cfg.bank_bits) - 4'd1);
        o_chunk.slave_address = i_cfg.base_addr | {4'd0, bank & bank_mask, 1'b0};
        o_chunk.length = n;
        o_chunk.last   = (n == i_left);
    end

endmodule

// ----- src/etcp_checker.sv -----
// ----------------------------------------------------------------------------
// etcp_checker
// Port-level checks for the EEPROM transfer chunk planner.
// ----------------------------------------------------------------------------
module etcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_res_status,
    input logic [7:0]  i_res_chunk_length,
    input logic        i_res_last,
    input logic [15:0] i_res_word_address
);
    import etcp_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_chunk_length)
            && $stable(i_res_status) && $stable(i_res_last))
        else $error("stalled result changed");

    // refusals are single, empty results
    a_refuse_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status != ST_OK) |->
            i_res_last && (i_res_chunk_length == 8'd0) && (i_res_word_address == 16'd0))
        else $error("refusal carries a transfer");

    // a chunk with bytes is always ok
    a_chunk_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_chunk_length != 8'd0) |-> (i_res_status == ST_OK))
        else $error("chunk with bad status");

    // one request at a time: not ready right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after accept");

endmodule

bind eeprom_transfer_chunk_planner etcp_checker u_etcp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_res_status       (o_res.status),
    .i_res_chunk_length (o_res.chunk_length),
    .i_res_last         (o_res.last),
    .i_res_word_address (o_res.word_address)
);

// ----- tb/etcp_chunk_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etcp_chunk_checker
// Watches the request, result and register ports of the chunk planner, plans
// the bus chunks of every accepted request on its own copy of the cursor and
// the settings, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module etcp_chunk_checker #(
    parameter int MAX_REQUEST_BYTES = 255,
    parameter int CURSOR_BITS       = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    etcp_req_if                                i_req,
    etcp_res_if                                i_res,
    input  logic                               i_cfg_we,
    input  logic [etcp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [etcp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import etcp_pkg::*;

    logic [7:0]         cfg_base;
    logic [1:0]         cfg_wa_bytes;
    logic [1:0]         cfg_bank_bits;
    logic [3:0]         cfg_page_log2;
    logic [20:0]        cfg_capacity;
    logic               dev_open;
    logic [CURSOR_BITS:0] cursor_pos;
    t_result            expected_chunks[$];
    int                 failures = 0;

    function automatic string show_chunk(input t_result r);
        return $sformatf("status=%0d sla=%02h wa=%04h len=%0d wr=%0d last=%0d",
                         r.status, r.slave_address, r.word_address,
                         r.chunk_length, r.is_write, r.last);
    endfunction

    task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_BASE_ADDR: cfg_base      = value[7:0];
            REG_WA_BYTES:  cfg_wa_bytes  = value[1:0];
            REG_BANK_BITS: cfg_bank_bits = value[1:0];
            REG_PAGE_LOG2: cfg_page_log2 = value[3:0];
            REG_CAPACITY:  cfg_capacity  = value[20:0];
            default: ;
        endcase
    endtask

    // Work out every result transaction that one request causes.
    task automatic plan_chunks(input logic [1:0] op, input logic [7:0] len,
                               input logic ack);
        t_result     r;
        int unsigned wab, pl, bank_size, page_size, eff_cap, addr, left_bytes;
        int unsigned off, room, page_room, n, bank_idx;
        logic        wr;
        r = '0;
        r.last = 1'b1;
        wr = (op == OP_WRITE);
        eff_cap = (cfg_capacity < (32'd1 << CURSOR_BITS)) ? cfg_capacity
                                                          : (32'd1 << CURSOR_BITS);
        if (op == OP_OPEN) begin
            if (!ack) begin
                r.status = ST_NO_DEVICE;
            end else begin
                cursor_pos = '0;
                dev_open = 1'b1;
            end
            expected_chunks.push_back(r);
        end else if (op == OP_CLOSE) begin
            dev_open = 1'b0;
            expected_chunks.push_back(r);
        end else if (!dev_open) begin
            r.status = ST_NOT_OPEN;
            expected_chunks.push_back(r);
        end else if (len > MAX_REQUEST_BYTES || int'(cursor_pos) + len > eff_cap) begin
            r.status = ST_CAPACITY;
            expected_chunks.push_back(r);
        end else if (len == 0) begin
            expected_chunks.push_back(r);
        end else begin
            // Clamp out-of-range settings the way the block does.
            wab = (cfg_wa_bytes == 0) ? 1 : ((cfg_wa_bytes > 2) ? 2 : cfg_wa_bytes);
            pl = (cfg_page_log2 < 3) ? 3 : ((cfg_page_log2 > 8) ? 8 : cfg_page_log2);
            bank_size = 32'd1 << (8 * wab);
            page_size = 32'd1 << pl;
            addr = cursor_pos;
            left_bytes = len;
            while (left_bytes != 0) begin
                off = addr & (bank_size - 1);
                room = bank_size - off;
                if (wr) begin
                    page_room = page_size - (addr & (page_size - 1));
                    if (page_room < room) room = page_room;
                end
                n = (left_bytes < room) ? left_bytes : room;
                bank_idx = (addr >> (8 * wab)) & ((32'd1 << cfg_bank_bits) - 1);
                left_bytes -= n;
                r.status        = ST_OK;
                r.slave_address = 8'(cfg_base | (bank_idx << 1));
                r.word_address  = 16'(off);
                r.chunk_length  = 8'(n);
                r.is_write      = wr;
                r.last          = (left_bytes == 0);
                expected_chunks.push_back(r);
                addr += n;
            end
            cursor_pos = addr[CURSOR_BITS:0];
        end
    endtask

    task automatic check_chunk(input t_result got);
        t_result want;
        if (expected_chunks.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: got %s", show_chunk(got));
        end else begin
            want = expected_chunks.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch: expected %s, got %s",
                             show_chunk(want), show_chunk(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            cfg_base      = RST_BASE_ADDR;
            cfg_wa_bytes  = RST_WA_BYTES;
            cfg_bank_bits = RST_BANK_BITS;
            cfg_page_log2 = RST_PAGE_LOG2;
            cfg_capacity  = RST_CAPACITY;
            dev_open      = 1'b0;
            cursor_pos    = '0;
            expected_chunks.delete();
        end else begin
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_data);
            if (i_res.valid && i_res.ready) begin
                got.status        = i_res.status;
                got.slave_address = i_res.slave_address;
                got.word_address  = i_res.word_address;
                got.chunk_length  = i_res.chunk_length;
                got.is_write      = i_res.is_write;
                got.last          = i_res.last;
                check_chunk(got);
            end
            if (i_req.valid && i_req.ready)
                plan_chunks(i_req.op, i_req.length, i_req.device_ack);
        end
        o_pending    <= expected_chunks.size();
        o_fail_count <= failures;
    end

endmodule

// ----- tb/tb_eeprom_transfer_chunk_planner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eeprom_transfer_chunk_planner
// Drives open, close, read and write requests into the chunk planner under
// several register settings and random handshake idling; a separate checker
// predicts every result transaction and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_eeprom_transfer_chunk_planner;
    import etcp_pkg::*;

    localparam int MAX_REQUEST_BYTES  = 255;
    localparam int CURSOR_BITS        = 20;
    // Slowest run: ~300 requests x 33 chunks, each chunk stalled by a busy
    // receiver, plus sender gaps and the long hold; taken several times over.
    localparam int CYCLE_LIMIT        = 400000;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES        = 40;
    localparam int PHASES             = 6;
    localparam int REQUESTS_PER_PHASE = 36;
    localparam int BURST_REQUESTS     = 20;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       src_idle_pct = 0;
    int                       sink_idle_pct = 0;
    int                       hold_request = 0;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;

    etcp_req_if req_ch();
    etcp_res_if res_ch();

    always #1 clk = ~clk;

    eeprom_transfer_chunk_planner #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
        .CURSOR_BITS       (CURSOR_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    etcp_chunk_checker #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
        .CURSOR_BITS       (CURSOR_BITS)
    ) u_chunk_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result receiver: drop ready at random, or for a long stretch whenever
    // the main sequence bumps hold_request.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != hold_seen) begin
                hold_seen = hold_request;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Write one register; the write lands on the edge after the one it is set up.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_settings(input logic [7:0] base, input logic [1:0] wa_bytes,
                                 input logic [1:0] bank_bits, input logic [3:0] page_log2,
                                 input int unsigned capacity);
        write_reg(REG_BASE_ADDR, 32'(base));
        write_reg(REG_WA_BYTES, 32'(wa_bytes));
        write_reg(REG_BANK_BITS, 32'(bank_bits));
        write_reg(REG_PAGE_LOG2, 32'(page_log2));
        write_reg(REG_CAPACITY, capacity);
    endtask

    // Stop offering and hold until every predicted result has come back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
    endtask

    // Offer one request transaction and hold it until accepted.
    task automatic send_req(input logic [1:0] op, input logic [7:0] len, input logic ack);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.length     <= len;
        req_ch.device_ack <= ack;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Mostly transfers with random lengths, occasional opens and closes to
    // rewind the cursor or shut the device.
    task automatic random_request();
        int unsigned pick;
        logic [1:0]  op;
        logic [7:0]  len;
        logic        ack;
        pick = $urandom_range(0, 99);
        if (pick < 8)       op = OP_OPEN;
        else if (pick < 12) op = OP_CLOSE;
        else if (pick < 52) op = OP_READ;
        else                op = OP_WRITE;
        case ($urandom_range(0, 3))
            0:       len = 8'($urandom_range(0, 9));
            1:       len = 8'($urandom_range(240, 255));
            default: len = 8'($urandom_range(0, 255));
        endcase
        ack = ($urandom_range(0, 9) != 0);
        send_req(op, len, ack);
    endtask

    task automatic random_settings();
        logic [3:0]  page_log2;
        int unsigned capacity;
        // Mostly legal page sizes, now and then a value the block clamps.
        page_log2 = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(3, 8));
        case ($urandom_range(0, 3))
            0:       capacity = $urandom_range(1, 700);
            1:       capacity = $urandom_range(700, 70000);
            2:       capacity = 32'h1F_FFFF;
            default: capacity = 32'd1 << CURSOR_BITS;
        endcase
        load_settings(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), page_log2, capacity);
    endtask

    task automatic run_directed();
        // Reset settings: transfers while closed, failed probe, a good open with transfers, then a close.
        send_req(OP_READ, 8'd0, 1'b1);
        send_req(OP_WRITE, 8'd255, 1'b1);
        send_req(OP_OPEN, 8'd0, 1'b0);
        send_req(OP_OPEN, 8'd255, 1'b1);
        send_req(OP_READ, 8'd0, 1'b0);
        send_req(OP_WRITE, 8'd255, 1'b0);
        send_req(OP_READ, 8'd255, 1'b1);
        send_req(OP_CLOSE, 8'd255, 1'b1);
        send_req(OP_READ, 8'd5, 1'b1);
        settle();

        // One-byte word address, eight-byte pages, small device with bank bits:
        // the worst-case write, a read across a bank, then the capacity edge.
        load_settings(8'h00, 2'd1, 2'd3, 4'd3, 1024);
        send_req(OP_OPEN, 8'd0, 1'b1);
        send_req(OP_WRITE, 8'd2, 1'b0);
        send_req(OP_WRITE, 8'd255, 1'b0);
        send_req(OP_READ, 8'd255, 1'b0);
        send_req(OP_READ, 8'd255, 1'b0);
        send_req(OP_READ, 8'd255, 1'b0);
        send_req(OP_READ, 8'd2, 1'b0);
        send_req(OP_WRITE, 8'd1, 1'b0);
        send_req(OP_READ, 8'd0, 1'b0);
        settle();

        // Zero capacity with clamped word address and page settings.
        load_settings(8'hFF, 2'd3, 2'd2, 4'd15, 0);
        send_req(OP_OPEN, 8'd7, 1'b1);
        send_req(OP_WRITE, 8'd0, 1'b1);
        send_req(OP_READ, 8'd1, 1'b1);
        settle();

        // Capacity above the cursor range; page size below the minimum.
        load_settings(8'hA0, 2'd0, 2'd0, 4'd0, 32'h1F_FFFF);
        send_req(OP_OPEN, 8'd0, 1'b1);
        send_req(OP_WRITE, 8'd255, 1'b0);
        send_req(OP_READ, 8'd255, 1'b0);
        settle();
    endtask

    // Watchdog: end the run if the traffic never drains.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int phase;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_OPEN;
        req_ch.length     <= 8'd0;
        req_ch.device_ack <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_BASE_ADDR;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(33, 68);
        run_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            // Swap the idling sides at phase 2, then run back to back from phase 4.
            if (phase == 2) set_idling(68, 33);
            if (phase == 4) set_idling(0, 0);
            random_settings();
            repeat (REQUESTS_PER_PHASE) random_request();
            if (phase == PHASES - 1) begin
                // Stall the receiver while requests keep coming so the block
                // backs up and pushes back on its input.
                hold_request <= hold_request + 1;
                repeat (BURST_REQUESTS) random_request();
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
